// ----- hdl/ccs_pkg.sv -----
package ccs_pkg;

   // Field widths fixed by the request and result formats
   localparam int CENTER_W = 15;
   localparam int RADIUS_W = 8;
   localparam int OFFSET_W = 9;
   localparam int COLOR_W  = 16;
   localparam int COORD_W  = 16;

   // Square root: radicand width, steps, steps per pipeline stage
   localparam int ROOT_W          = 16;
   localparam int HALF_W          = 8;
   localparam int ROOT_STEPS      = 8;
   localparam int STEPS_PER_STAGE = 2;
   localparam int ROOT_STAGES     = ROOT_STEPS / STEPS_PER_STAGE;

   // Request fields that ride alongside the root computation
   typedef struct packed {
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic signed [OFFSET_W-1:0] column_offset;
      logic [COLOR_W-1:0]         fill_color;
      logic                       in_range;
   } ccs_side_type;

   // Digit-by-digit square root state: remaining radicand and partial root
   typedef struct packed {
      logic [ROOT_W-1:0] op;
      logic [ROOT_W-1:0] res;
   } ccs_root_type;

   // One restoring root step for the given bit weight (one = 4^k)
   function automatic ccs_root_type root_step(ccs_root_type v, logic [ROOT_W-1:0] one);
      ccs_root_type      r;
      logic [ROOT_W-1:0] sum;
      sum = v.res + one;
      if (v.op >= sum) begin
         r.op  = v.op - sum;
         r.res = (v.res >> 1) + one;
      end else begin
         r.op  = v.op;
         r.res = v.res >> 1;
      end
      return r;
   endfunction

endpackage

// ----- hdl/ccs_front.sv -----
module ccs_front import ccs_pkg::*; #(
   parameter int MAX_RADIUS = 181
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [CENTER_W-1:0] in_center_x,
   input  logic signed [CENTER_W-1:0] in_center_y,
   input  logic [RADIUS_W-1:0]        in_radius_px,
   input  logic signed [OFFSET_W-1:0] in_column_offset,
   input  logic [COLOR_W-1:0]         in_fill_color,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [ROOT_W-1:0]          out_rem,
   output ccs_side_type               out_side
);

   localparam logic [RADIUS_W-1:0] RMAX = RADIUS_W'(MAX_RADIUS);

   logic                       a_valid_ff, a_valid_in;
   logic [ROOT_W-1:0]          a_rr_ff, a_rr_in;
   logic [ROOT_W-1:0]          a_dd_ff, a_dd_in;
   ccs_side_type               a_side_ff, a_side_in;
   logic                       b_valid_ff, b_valid_in;
   logic [ROOT_W-1:0]          b_rem_ff, b_rem_in;
   ccs_side_type               b_side_ff, b_side_in;
   logic                       a_ready, b_ready;
   logic [RADIUS_W-1:0]        r_clamp, sq_r, sq_d;
   logic signed [OFFSET_W:0]   r_s, dx_s, dx_abs;
   logic                       ok;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Clamp radius, range check and square both terms
   always_comb begin
      r_clamp = (in_radius_px > RMAX) ? RMAX : in_radius_px;
      r_s     = $signed({2'b00, r_clamp});
      dx_s    = {in_column_offset[OFFSET_W-1], in_column_offset};
      ok      = (dx_s >= -r_s) && (dx_s <= r_s - 10'sd1);
      dx_abs  = dx_s[OFFSET_W] ? -dx_s : dx_s;
      sq_r    = ok ? r_clamp : '0;
      sq_d    = ok ? dx_abs[RADIUS_W-1:0] : '0;

      a_valid_in = a_ready ? in_valid : a_valid_ff;
      a_rr_in    = a_rr_ff;
      a_dd_in    = a_dd_ff;
      a_side_in  = a_side_ff;
      if (a_ready && in_valid) begin
         a_rr_in                 = ROOT_W'(sq_r) * ROOT_W'(sq_r);
         a_dd_in                 = ROOT_W'(sq_d) * ROOT_W'(sq_d);
         a_side_in.center_x      = in_center_x;
         a_side_in.center_y      = in_center_y;
         a_side_in.column_offset = in_column_offset;
         a_side_in.fill_color    = in_fill_color;
         a_side_in.in_range      = ok;
      end
   end

   // Radicand r*r - dx*dx
   always_comb begin
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_rem_in   = b_rem_ff;
      b_side_in  = b_side_ff;
      if (b_ready && a_valid_ff) begin
         b_rem_in  = a_rr_ff - a_dd_ff;
         b_side_in = a_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_rr_ff   <= a_rr_in;
      a_dd_ff   <= a_dd_in;
      a_side_ff <= a_side_in;
      b_rem_ff  <= b_rem_in;
      b_side_ff <= b_side_in;
   end

   assign out_valid = b_valid_ff;
   assign out_rem   = b_rem_ff;
   assign out_side  = b_side_ff;

endmodule

// ----- hdl/ccs_root_stage.sv -----
module ccs_root_stage import ccs_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  ccs_root_type in_root,
   input  ccs_side_type in_side,
   output logic         out_valid,
   input  logic         out_ready,
   output ccs_root_type out_root,
   output ccs_side_type out_side
);

   // Bit weights 4^k for the two steps done here, highest first
   localparam int FIRST_SH  = (ROOT_W - 2) - 2 * STEPS_PER_STAGE * STAGE;
   localparam logic [ROOT_W-1:0] ONE_A = ROOT_W'(1) << FIRST_SH;
   localparam logic [ROOT_W-1:0] ONE_B = ROOT_W'(1) << (FIRST_SH - 2);

   logic         valid_ff, valid_in;
   ccs_root_type root_ff, root_in;
   ccs_side_type side_ff, side_in;
   logic         ready;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   // Two root steps per stage
   always_comb begin
      valid_in = ready ? in_valid : valid_ff;
      root_in  = root_ff;
      side_in  = side_ff;
      if (ready && in_valid) begin
         root_in = root_step(root_step(in_root, ONE_A), ONE_B);
         side_in = in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
      side_ff <= side_in;
   end

   assign out_valid = valid_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// ----- hdl/circle_column_span.sv -----
// Channel | Direction | Ports                                                  | Handshake
// req     | in        | center_x center_y radius_px column_offset fill_color   | req_valid/req_ready
// rsp     | out       | column_x span_top span_end span_color in_range          | rsp_valid/rsp_ready
//
// Seven register stages: square terms, radicand, four root stages of two
// digits each, output adders. One request per cycle while the output is not stalled.
// Throughput is set by the pipeline only: every stage takes a new request
// each cycle while it is empty or its downstream stage is moving.
// Synchronous reset clears the valid bits only; data registers hold.
// A stalled output holds its stage; bubbles still collapse upstream.
module circle_column_span import ccs_pkg::*; #(
   parameter int MAX_RADIUS = 181
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [CENTER_W-1:0] req_center_x,
   input  logic signed [CENTER_W-1:0] req_center_y,
   input  logic [RADIUS_W-1:0]        req_radius_px,
   input  logic signed [OFFSET_W-1:0] req_column_offset,
   input  logic [COLOR_W-1:0]         req_fill_color,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COORD_W-1:0]  rsp_column_x,
   output logic signed [COORD_W-1:0]  rsp_span_top,
   output logic signed [COORD_W-1:0]  rsp_span_end,
   output logic [COLOR_W-1:0]         rsp_span_color,
   output logic                       rsp_in_range
);

   logic                  st_valid [ROOT_STAGES+1];
   logic                  st_ready [ROOT_STAGES+1];
   ccs_root_type          st_root  [ROOT_STAGES+1];
   ccs_side_type          st_side  [ROOT_STAGES+1];
   logic [ROOT_W-1:0]     front_rem;

   logic                  o_valid_ff, o_valid_in;
   logic [COORD_W-1:0]    o_x_ff, o_x_in;
   logic [COORD_W-1:0]    o_top_ff, o_top_in;
   logic [COORD_W-1:0]    o_end_ff, o_end_in;
   logic [COLOR_W-1:0]    o_color_ff, o_color_in;
   logic                  o_range_ff, o_range_in;
   logic                  o_ready;
   logic [HALF_W-1:0]     half;
   logic [COORD_W-1:0]    cy_ext;
   ccs_side_type          last_side;

   // Clamp, range check, squares and radicand
   ccs_front #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .in_center_x      (req_center_x),
      .in_center_y      (req_center_y),
      .in_radius_px     (req_radius_px),
      .in_column_offset (req_column_offset),
      .in_fill_color    (req_fill_color),
      .out_valid        (st_valid[0]),
      .out_ready        (st_ready[0]),
      .out_rem          (front_rem),
      .out_side         (st_side[0])
   );

   assign st_root[0].op  = front_rem;
   assign st_root[0].res = '0;

   // Square root pipeline
   for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
      ccs_root_stage #(
         .STAGE(g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[g]),
         .in_ready  (st_ready[g]),
         .in_root   (st_root[g]),
         .in_side   (st_side[g]),
         .out_valid (st_valid[g+1]),
         .out_ready (st_ready[g+1]),
         .out_root  (st_root[g+1]),
         .out_side  (st_side[g+1])
      );
   end

   assign o_ready                = !o_valid_ff || rsp_ready;
   assign st_ready[ROOT_STAGES]  = o_ready;
   assign last_side              = st_side[ROOT_STAGES];
   assign half                   = st_root[ROOT_STAGES].res[HALF_W-1:0];

   // Output stage: column and span edges
   always_comb begin
      cy_ext     = {last_side.center_y[CENTER_W-1], last_side.center_y};
      o_valid_in = o_ready ? st_valid[ROOT_STAGES] : o_valid_ff;
      o_x_in     = o_x_ff;
      o_top_in   = o_top_ff;
      o_end_in   = o_end_ff;
      o_color_in = o_color_ff;
      o_range_in = o_range_ff;
      if (o_ready && st_valid[ROOT_STAGES]) begin
         o_x_in     = {last_side.center_x[CENTER_W-1], last_side.center_x}
                    + {{(COORD_W-OFFSET_W){last_side.column_offset[OFFSET_W-1]}},
                       last_side.column_offset};
         o_top_in   = cy_ext - {{(COORD_W-HALF_W){1'b0}}, half};
         o_end_in   = cy_ext + {{(COORD_W-HALF_W){1'b0}}, half};
         o_color_in = last_side.fill_color;
         o_range_in = last_side.in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      o_x_ff     <= o_x_in;
      o_top_ff   <= o_top_in;
      o_end_ff   <= o_end_in;
      o_color_ff <= o_color_in;
      o_range_ff <= o_range_in;
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_column_x   = o_x_ff;
   assign rsp_span_top   = o_top_ff;
   assign rsp_span_end   = o_end_ff;
   assign rsp_span_color = o_color_ff;
   assign rsp_in_range   = o_range_ff;

endmodule

// ----- test/ccs_span_checker.sv -----
module ccs_span_checker
   import ccs_pkg::*;
#(
   parameter int MAX_RADIUS = 181
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [CENTER_W-1:0] req_center_x,
   input  logic signed [CENTER_W-1:0] req_center_y,
   input  logic [RADIUS_W-1:0]        req_radius_px,
   input  logic signed [OFFSET_W-1:0] req_column_offset,
   input  logic [COLOR_W-1:0]         req_fill_color,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [COORD_W-1:0]  rsp_column_x,
   input  logic signed [COORD_W-1:0]  rsp_span_top,
   input  logic signed [COORD_W-1:0]  rsp_span_end,
   input  logic [COLOR_W-1:0]         rsp_span_color,
   input  logic                       rsp_in_range,
   output int                         fail_count,
   output int                         spans_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [COORD_W-1:0] column_x;
      logic signed [COORD_W-1:0] span_top;
      logic signed [COORD_W-1:0] span_end;
      logic [COLOR_W-1:0]        span_color;
      logic                      in_range;
   } column_span_type;

   column_span_type expected_spans[$];

   initial begin
      fail_count    = 0;
      spans_pending = 0;
   end

   // Column span of a filled circle: clamp radius, range check, floor of the root
   function automatic column_span_type column_span(
      input logic signed [CENTER_W-1:0] cx,
      input logic signed [CENTER_W-1:0] cy,
      input logic [RADIUS_W-1:0]        rad,
      input logic signed [OFFSET_W-1:0] dx,
      input logic [COLOR_W-1:0]         color
   );
      column_span_type span;
      int              r;
      int              offset;
      int              radicand;
      int              half;
      int              trial;
      logic            hit;
      r      = (int'(rad) > MAX_RADIUS) ? MAX_RADIUS : int'(rad);
      offset = int'(dx);
      hit    = (offset >= -r) && (offset <= r - 1);
      half   = 0;
      if (hit) begin
         radicand = r * r - offset * offset;
         // build the root one bit at a time, MSB first
         for (int b = HALF_W - 1; b >= 0; b--) begin
            trial = half | (1 << b);
            if (trial * trial <= radicand) half = trial;
         end
      end
      span.column_x   = COORD_W'(int'(cx) + offset);
      span.span_top   = COORD_W'(int'(cy) - half);
      span.span_end   = COORD_W'(int'(cy) + half);
      span.span_color = color;
      span.in_range   = hit;
      return span;
   endfunction

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Track requests in, compare spans out in order
   always @(posedge clock) begin
      column_span_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_spans.push_back(column_span(req_center_x, req_center_y, req_radius_px,
                                                 req_column_offset, req_fill_color));
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               $error("span result with no request outstanding");
               fail_count++;
            end else begin
               want = expected_spans.pop_front();
               compare_field("column_x", want.column_x, rsp_column_x);
               compare_field("span_top", want.span_top, rsp_span_top);
               compare_field("span_end", want.span_end, rsp_span_end);
               compare_field("span_color", {16'd0, want.span_color}, {16'd0, rsp_span_color});
               compare_field("in_range", {31'd0, want.in_range}, {31'd0, rsp_in_range});
            end
         end
         spans_pending = expected_spans.size();
      end
   end

endmodule

// ----- test/tb_circle_column_span.sv -----
module tb_circle_column_span;
   timeunit 1ns;
   timeprecision 1ps;
   import ccs_pkg::*;

   localparam int MAX_RADIUS      = 181;
   localparam int RANDOM_REQUESTS = 1800;
   localparam int TIMEOUT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_CYCLES     = 80;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic signed [CENTER_W-1:0] req_center_x      = '0;
   logic signed [CENTER_W-1:0] req_center_y      = '0;
   logic [RADIUS_W-1:0]        req_radius_px     = '0;
   logic signed [OFFSET_W-1:0] req_column_offset = '0;
   logic [COLOR_W-1:0]         req_fill_color    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic signed [COORD_W-1:0]  rsp_column_x;
   logic signed [COORD_W-1:0]  rsp_span_top;
   logic signed [COORD_W-1:0]  rsp_span_end;
   logic [COLOR_W-1:0]         rsp_span_color;
   logic                       rsp_in_range;

   int fail_count;
   int spans_pending;
   int cycle_count   = 0;
   bit hold_request  = 1'b0;

   circle_column_span #(.MAX_RADIUS(MAX_RADIUS)) dut (.*);

   ccs_span_checker #(.MAX_RADIUS(MAX_RADIUS)) u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("circle_column_span test failed");
         $finish;
      end
   end

   // Result side: stretches of different stall patterns, plus a long hold on demand
   initial begin
      int mode;
      int stretch;
      int tick;
      stretch = 0;
      mode    = 0;
      tick    = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (stretch == 0) begin
               mode    = $urandom_range(0, 3);
               stretch = $urandom_range(20, 150);
            end
            stretch--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 9) < 7);
               2: rsp_ready <= (tick % 3 == 0);
               default: rsp_ready <= tick[0];
            endcase
         end
      end
   end

   task automatic send_request(input int cx, input int cy, input int rad, input int dx,
                               input int color);
      req_valid         <= 1'b1;
      req_center_x      <= CENTER_W'(cx);
      req_center_y      <= CENTER_W'(cy);
      req_radius_px     <= RADIUS_W'(rad);
      req_column_offset <= OFFSET_W'(dx);
      req_fill_color    <= COLOR_W'(color);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly in-range columns of legal circles, some oversized radii and stray offsets
   task automatic send_random_request();
      int rad;
      int r;
      int dx;
      case ($urandom_range(0, 19))
         0:       rad = 0;
         1:       rad = 1;
         2:       rad = MAX_RADIUS;
         3, 4:    rad = $urandom_range(MAX_RADIUS + 1, 255);
         5, 6, 7: rad = $urandom_range(1, 8);
         default: rad = $urandom_range(0, MAX_RADIUS);
      endcase
      r = (rad > MAX_RADIUS) ? MAX_RADIUS : rad;
      if (r > 0 && $urandom_range(0, 9) < 8)
         dx = int'($urandom_range(0, 2 * r - 1)) - r;
      else
         dx = int'($urandom_range(0, 511)) - 256;
      send_request(int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)), rad, dx,
                   int'($urandom_range(0, 65535)));
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every outstanding span
   task automatic wait_for_spans();
      req_valid <= 1'b0;
      do @(negedge clock); while (spans_pending != 0);
      @(posedge clock);
   endtask

   // Request side
   initial begin
      int  sent;
      int  burst;
      bit  hold_done;
      bit  pause_done;
      sent       = 0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corners: field extremes, radius clamp, range edges
      send_request(-16384, -16384, 181, 0, 0);
      send_request(16383, 16383, 181, 0, 65535);
      send_request(16383, -16384, 181, -181, 16'h5a5a);
      send_request(-16384, 16383, 181, 180, 16'ha5a5);
      send_request(16383, 16383, 181, 181, 1);
      send_request(-16384, -16384, 181, -182, 2);
      send_request(100, 200, 0, 0, 3);
      send_request(100, 200, 0, -1, 4);
      send_request(-5, 7, 1, -1, 5);
      send_request(-5, 7, 1, 0, 6);
      send_request(-5, 7, 1, 1, 7);
      send_request(0, 0, 182, 0, 8);
      send_request(0, 0, 255, -181, 9);
      send_request(0, 0, 255, 181, 10);
      send_request(0, 0, 255, 255, 11);
      send_request(0, 0, 255, -256, 12);
      send_request(12, -34, 5, 3, 13);
      send_request(12, -34, 5, -5, 14);
      send_request(12, -34, 5, 4, 15);
      send_request(-1, -1, 100, -60, 16'hffff);
      send_request(16383, 16383, 127, 255, 16'h8000);
      send_request(-16384, -16384, 128, -256, 16'h0001);
      wait_for_spans();

      // random bursts with gaps; one long result hold, one full drain
      while (sent < RANDOM_REQUESTS) begin
         if (sent >= 600 && !hold_done) begin
            hold_done    = 1'b1;
            hold_request = 1'b1;
            repeat (40) begin
               send_random_request();
               sent++;
            end
         end else if (sent >= 1200 && !pause_done) begin
            pause_done = 1'b1;
            wait_for_spans();
         end else begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120)
                                                 : $urandom_range(1, 24);
            repeat (burst) begin
               send_random_request();
               sent++;
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
         end
      end

      wait_for_spans();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("circle_column_span test passed");
      else
         $display("circle_column_span test failed");
      $finish;
   end

endmodule
